// ----- hw/rtl/tsc_pkg.sv -----
`timescale 1ns / 1ps

package tsc_pkg;

    // Fixed three-phase winding set per motor.
    localparam int WINDINGS = 3;

    // Item kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SPEED = 2'd1;
    localparam logic [1:0] KIND_LAG   = 2'd2;

    // Register indexes on the write port.
    localparam logic [2:0] CFG_TIMER_PERIOD = 3'd0;
    localparam logic [2:0] CFG_PCT_ROLL     = 3'd1;
    localparam logic [2:0] CFG_PCT_PITCH    = 3'd2;
    localparam logic [2:0] CFG_PCT_YAW      = 3'd3;
    localparam logic [2:0] CFG_SLEW_ROLL    = 3'd4;
    localparam logic [2:0] CFG_SLEW_PITCH   = 3'd5;
    localparam logic [2:0] CFG_SLEW_YAW     = 3'd6;
    localparam logic [2:0] CFG_OUTPUTS      = 3'd7;

    localparam int CFG_DATA_BITS = 24;

    // Reset values of the registers.
    localparam logic [15:0] TIMER_PERIOD_RST = 16'd1000;
    localparam logic [3:0]  OUTPUTS_RST      = 4'd9;

    // Full scale of the power percentage.
    localparam logic [6:0] PCT_FULL = 7'd100;

    // Last winding of a motor.
    localparam logic [1:0] WINDING_LAST = 2'(WINDINGS - 1);

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         motor;
        logic signed [31:0] target_speed;
        logic [7:0]         elapsed_ticks;
        logic [31:0]        lag_phase;
    } tsc_in_t;

    typedef struct packed {
        logic [3:0]  output_index;
        logic [15:0] compare_value;
        logic        last;
    } tsc_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       lag_write;
        logic       speed_load;
        logic       speed_write;
        logic       advance;
        logic       emit;
        logic       last;
        logic [1:0] motor;
        logic [1:0] winding;
    } tsc_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic       any_wired;
        logic [1:0] last_motor;
    } tsc_stat_t;

endpackage

// ----- hw/rtl/tsc_sine_rom.sv -----
`timescale 1ns / 1ps

module tsc_sine_rom
    import tsc_pkg::*;
#(
    parameter int ADDR_BITS = 10
) (
    input  logic                 aclk,
    input  logic [ADDR_BITS-2:0] addr,
    output logic [14:0]          mag
);

    localparam int QBITS = ADDR_BITS - 2;
    localparam int DEPTH = (1 << QBITS) + 1;

    localparam longint unsigned COEF_C1 = 64'd1686629713;
    localparam longint unsigned COEF_C3 = 64'd693598668;
    localparam longint unsigned COEF_C5 = 64'd85569306;
    localparam longint unsigned COEF_C7 = 64'd5026996;
    localparam longint unsigned COEF_C9 = 64'd172272;

    // Quarter-wave magnitude at position pos (0..2^qbits), odd polynomial in Q30.
    function automatic logic [14:0] quarter_mag(input int unsigned pos,
                                                input int unsigned qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = 64'(pos) << (16 - qbits);
        x2 = (x * x) >> 16;
        t  = COEF_C9;
        t  = COEF_C7 - ((x2 * t) >> 16);
        t  = COEF_C5 - ((x2 * t) >> 16);
        t  = COEF_C3 - ((x2 * t) >> 16);
        t  = COEF_C1 - ((x2 * t) >> 16);
        s  = (x * t) >> 16;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[14:0];
    endfunction

    logic [14:0] rom [DEPTH];
    logic [14:0] mag_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_rom
        assign rom[i] = quarter_mag(i, QBITS);
    end

    always_ff @(posedge aclk) begin
        mag_reg <= rom[addr];
    end

    assign mag = mag_reg;

endmodule

// ----- hw/rtl/tsc_ctrl.sv -----
`timescale 1ns / 1ps

module tsc_ctrl
    import tsc_pkg::*;
#(
    parameter int MOTORS = 3
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic [1:0] s_kind,
    input  logic [1:0] s_motor,
    output logic      m_valid,
    input  logic      m_ready,
    input  tsc_stat_t stat,
    output tsc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPEED_WR,
        ST_ANGLE,
        ST_LOOKUP,
        ST_SCALE,
        ST_PERCENT,
        ST_RECIP,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] mot_reg, mot_next;
    logic [1:0] wnd_reg, wnd_next;
    logic       out_valid_reg, out_valid_next;

    logic accept;
    logic motor_ok;
    logic out_free;
    logic last_out;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign motor_ok = (s_motor < 2'(MOTORS));
    assign out_free = !out_valid_reg || m_ready;
    assign last_out = (mot_reg == stat.last_motor) && (wnd_reg == WINDING_LAST);
    assign m_valid  = out_valid_reg;

    always_comb begin
        cmd             = '0;
        cmd.lag_write   = accept && (s_kind == KIND_LAG) && motor_ok;
        cmd.speed_load  = accept && (s_kind == KIND_SPEED) && motor_ok;
        cmd.advance     = accept && (s_kind == KIND_TICK);
        cmd.speed_write = (state_reg == ST_SPEED_WR);
        cmd.emit        = (state_reg == ST_EMIT) && out_free;
        cmd.last        = last_out;
        cmd.motor       = mot_reg;
        cmd.winding     = wnd_reg;
    end

    always_comb begin
        state_next = state_reg;
        mot_next   = mot_reg;
        wnd_next   = wnd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_SPEED: begin
                            if (motor_ok) begin
                                state_next = ST_SPEED_WR;
                            end
                        end
                        KIND_TICK: begin
                            mot_next = '0;
                            wnd_next = '0;
                            if (stat.any_wired) begin
                                state_next = ST_ANGLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SPEED_WR: state_next = ST_IDLE;
            ST_ANGLE:    state_next = ST_LOOKUP;
            ST_LOOKUP:   state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_PERCENT;
            ST_PERCENT:  state_next = ST_RECIP;
            ST_RECIP:    state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (last_out) begin
                        state_next = ST_IDLE;
                    end else if (wnd_reg == WINDING_LAST) begin
                        wnd_next   = '0;
                        mot_next   = mot_reg + 2'd1;
                        state_next = ST_ANGLE;
                    end else begin
                        wnd_next   = wnd_reg + 2'd1;
                        state_next = ST_ANGLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mot_reg       <= '0;
            wnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mot_reg       <= mot_next;
            wnd_reg       <= wnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A held result is never overwritten.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_ready))
        else $error("emit while output register still full");

    // The final result of a tick frees the input side next cycle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> s_ready)
        else $error("input not ready after final result");

    // The sequencer stays within the wired motors and their windings.
    a_mot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (mot_reg <= stat.last_motor && wnd_reg <= WINDING_LAST))
        else $error("output sequencer out of range");

    // A result appears only after an emit.
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.emit))
        else $error("result valid without emit");

endmodule

// ----- hw/rtl/tsc_dpath.sv -----
`timescale 1ns / 1ps

module tsc_dpath
    import tsc_pkg::*;
#(
    parameter int MOTORS         = 3,
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tsc_in_t                  s_item,
    input  tsc_cmd_t                 cmd,
    output tsc_stat_t                stat,
    input  logic                     cfg_wr_en,
    input  logic [2:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output tsc_out_t                 m_item
);

    localparam int MW      = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int QBITS   = SINE_ADDR_BITS - 2;
    localparam int QUARTER = 1 << QBITS;

    localparam logic [16:0] SINE_ONE = 17'd32768;
    // floor(2^30 / 100); error below one count for 23-bit dividends.
    localparam logic [23:0] RECIP_100 = 24'd10737418;

    localparam logic [31:0] WINDING_SHIFT [WINDINGS] = '{
        32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAB
    };

    // Configuration
    logic [15:0] period_reg;
    logic [6:0]  pct_reg  [3];
    logic [23:0] slew_reg [3];
    logic [3:0]  outputs_reg;

    // Motor state
    logic [PHASE_BITS-1:0] acc_reg    [MOTORS];
    logic signed [31:0]    speed_reg  [MOTORS];
    logic [31:0]           offset_reg [MOTORS];

    // Speed update stage
    logic [32:0]   diff_reg;
    logic [31:0]   lim_reg;
    logic          slew_nz_reg;
    logic [MW-1:0] spd_mot_reg;

    // Compare value chain
    logic [QBITS:0] rom_addr_reg;
    logic           neg_p1_reg;
    logic           neg_p2_reg;
    logic [14:0]    mag;
    logic [30:0]    a_reg;
    logic [22:0]    c_reg;
    logic [16:0]    q0_reg;
    tsc_out_t       out_reg;

    logic [MW-1:0] mi;
    logic [MW-1:0] si;

    assign mi = MW'(cmd.motor);
    assign si = MW'(s_item.motor);

    // Wired motors: motor m needs 3*(m+1) outputs.
    logic [1:0] nwired;
    always_comb begin
        nwired = '0;
        for (int m = 0; m < MOTORS; m++) begin
            if (outputs_reg >= 4'(WINDINGS * (m + 1))) begin
                nwired = 2'(m + 1);
            end
        end
        stat.any_wired  = (nwired != 2'd0);
        stat.last_motor = nwired - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= TIMER_PERIOD_RST;
            outputs_reg <= OUTPUTS_RST;
            for (int i = 0; i < 3; i++) begin
                pct_reg[i]  <= '0;
                slew_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TIMER_PERIOD: period_reg  <= cfg_wdata[15:0];
                CFG_PCT_ROLL:     pct_reg[0]  <= cfg_wdata[6:0];
                CFG_PCT_PITCH:    pct_reg[1]  <= cfg_wdata[6:0];
                CFG_PCT_YAW:      pct_reg[2]  <= cfg_wdata[6:0];
                CFG_SLEW_ROLL:    slew_reg[0] <= cfg_wdata[23:0];
                CFG_SLEW_PITCH:   slew_reg[1] <= cfg_wdata[23:0];
                CFG_SLEW_YAW:     slew_reg[2] <= cfg_wdata[23:0];
                CFG_OUTPUTS:      outputs_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Speed slew: difference and limit first, clamp and add next cycle.
    logic signed [33:0] d34;
    logic signed [33:0] l34;
    logic signed [33:0] dcl;
    logic [31:0]        speed_new;

    always_comb begin
        d34 = {diff_reg[32], diff_reg};
        l34 = {2'b00, lim_reg};
        if (slew_nz_reg && (d34 > l34)) begin
            dcl = l34;
        end else if (slew_nz_reg && (d34 < -l34)) begin
            dcl = -l34;
        end else begin
            dcl = d34;
        end
        speed_new = speed_reg[spd_mot_reg] + dcl[31:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.speed_load) begin
            diff_reg    <= {s_item.target_speed[31], s_item.target_speed}
                         - {speed_reg[si][31], speed_reg[si]};
            lim_reg     <= 32'(slew_reg[s_item.motor]) * 32'(s_item.elapsed_ticks);
            slew_nz_reg <= (slew_reg[s_item.motor] != 24'd0);
            spd_mot_reg <= si;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < MOTORS; m++) begin
                acc_reg[m]    <= '0;
                speed_reg[m]  <= '0;
                offset_reg[m] <= '0;
            end
        end else begin
            if (cmd.advance) begin
                for (int m = 0; m < MOTORS; m++) begin
                    acc_reg[m] <= acc_reg[m] + speed_reg[m][31 -: PHASE_BITS];
                end
            end
            if (cmd.lag_write) begin
                offset_reg[si] <= s_item.lag_phase;
            end
            if (cmd.speed_write) begin
                speed_reg[spd_mot_reg] <= speed_new;
            end
        end
    end

    // Winding angle and quarter-wave table address.
    logic [31:0]               acc_full;
    logic [31:0]               angle;
    logic [SINE_ADDR_BITS-1:0] tab_idx;
    logic [QBITS-1:0]          quad_pos;

    always_comb begin
        acc_full = 32'({acc_reg[mi], 32'd0} >> PHASE_BITS);
        angle    = acc_full + offset_reg[mi] + WINDING_SHIFT[cmd.winding];
        tab_idx  = angle[31 -: SINE_ADDR_BITS];
        quad_pos = tab_idx[QBITS-1:0];
    end

    tsc_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr_reg),
        .mag  (mag)
    );

    logic [15:0] level;
    logic [6:0]  pct_cap;
    logic [37:0] scaled;
    logic [46:0] recip_prod;
    logic [22:0] rem;
    logic [16:0] quot;

    always_comb begin
        level      = neg_p2_reg ? 16'(SINE_ONE - 17'(mag)) : 16'(SINE_ONE + 17'(mag));
        pct_cap    = (pct_reg[cmd.motor] > PCT_FULL) ? PCT_FULL : pct_reg[cmd.motor];
        scaled     = 38'(a_reg) * 38'(pct_cap);
        recip_prod = 47'(c_reg) * 47'(RECIP_100);
        rem        = c_reg - 23'(q0_reg) * 23'(PCT_FULL);
        quot       = (rem >= 23'(PCT_FULL)) ? (q0_reg + 17'd1) : q0_reg;
    end

    // The chain reloads every cycle; the sequencer holds its inputs steady.
    always_ff @(posedge aclk) begin
        rom_addr_reg <= tab_idx[QBITS] ? ((QBITS+1)'(QUARTER) - {1'b0, quad_pos})
                                       : {1'b0, quad_pos};
        neg_p1_reg   <= tab_idx[SINE_ADDR_BITS-1];
        neg_p2_reg   <= neg_p1_reg;
        a_reg        <= 31'(period_reg[15:1]) * 31'(level);
        c_reg        <= scaled[37:15];
        q0_reg       <= recip_prod[46:30];
        if (cmd.emit) begin
            out_reg.output_index  <= 4'(cmd.motor) * 4'(WINDINGS) + 4'(cmd.winding);
            out_reg.compare_value <= quot[15:0];
            out_reg.last          <= cmd.last;
        end
    end

    assign m_item = out_reg;

endmodule

// ----- hw/rtl/three_phase_sine_commutator.sv -----
`timescale 1ns / 1ps

// Sinusoidal three-phase PWM commutator for up to three gimbal motors.
// Input channel (s_valid/s_ready/s_item) takes three kinds of beat: a tick
// advances every motor phase by its speed and yields the compare values of
// all wired outputs; a speed beat slews one motor's speed toward its target;
// a lag beat sets one motor's phase offset. Unknown kinds and motors are dropped.
// Result channel (m_valid/m_ready/m_item) carries one compare value per beat,
// in output order, with last set on the final beat of a tick.
// A lag beat sets the offset on acceptance; a speed beat registers its difference
// and limit, then writes the new speed. A tick emits its outputs one at a time via
// the single shared scaling chain (table lookup, two multiplies, reciprocal divide
// by 100 and its correction), through the angle, lookup, scale, percent, reciprocal
// and emit states; emit loads the output register and sets m_valid. That register
// holds each result; while the receiver stalls the chain waits in front of it, and
// the next item is taken as soon as the final result is loaded. The user must write
// configuration on cfg_wr_en only while idle; the block does not enforce this.
// Reset (aresetn low, synchronous) clears phases, speeds, offsets and all
// handshake state and restores the register reset values.
module three_phase_sine_commutator
    import tsc_pkg::*;
#(
    parameter int MOTORS         = 3,
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Input items
    input  logic                     s_valid,
    output logic                     s_ready,
    input  tsc_in_t                  s_item,
    // Result items
    output logic                     m_valid,
    input  logic                     m_ready,
    output tsc_out_t                 m_item,
    // Register writes
    input  logic                     cfg_wr_en,
    input  logic [2:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    tsc_cmd_t  cmd;
    tsc_stat_t stat;

    // Sequencer: decodes beats, steps through motors and windings, owns m_valid.
    tsc_ctrl #(
        .MOTORS (MOTORS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_item.kind),
        .s_motor (s_item.motor),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: registers, motor state, sine table and compare scaling.
    tsc_dpath #(
        .MOTORS         (MOTORS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .PHASE_BITS     (PHASE_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_item    (m_item)
    );

endmodule

// ----- tb/compare_value_checker.sv -----
`timescale 1ns / 1ps

module compare_value_checker
    import tsc_pkg::*;
#(
    parameter int MOTORS         = 3,
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  tsc_in_t                  s_item,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  tsc_out_t                 m_item,
    input  logic                     cfg_wr_en,
    input  logic [2:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output int                       fail_count,
    output int                       pending_beats
);

    localparam int QUAD_SHIFT = SINE_ADDR_BITS - 2;
    localparam logic [31:0] PHASE_KEEP = ~32'd0 << (32 - PHASE_BITS);
    localparam longint unsigned POLY_C1 = 64'd1686629713;
    localparam longint unsigned POLY_C3 = 64'd693598668;
    localparam longint unsigned POLY_C5 = 64'd85569306;
    localparam longint unsigned POLY_C7 = 64'd5026996;
    localparam longint unsigned POLY_C9 = 64'd172272;
    localparam longint unsigned FULL_SCALE = 64'd3276800;

    // Register copies
    logic [15:0] period_reg;
    logic [6:0]  pct_reg [3];
    logic [23:0] slew_reg [3];
    logic [3:0]  outputs_reg;

    // Motor state
    logic [31:0]        phase_turns [3];
    logic signed [31:0] speed_turns [3];
    logic [31:0]        lag_turns [3];

    tsc_out_t compare_due [$];
    tsc_out_t due;
    int       mismatches = 0;

    function automatic logic [31:0] winding_offset(input int w);
        return 32'(((longint'(w) << 32) + 1) / 3);
    endfunction

    // Scaled sine of the table entry addressed by the top bits of angle.
    function automatic logic [15:0] compare_level(input logic [31:0] angle,
                                                  input logic [6:0] pct);
        longint unsigned idx, quad, x, x2, poly, mag, half, level, scale;
        idx  = angle >> (32 - SINE_ADDR_BITS);
        quad = (idx >> QUAD_SHIFT) & 3;
        x    = (idx & ((64'd1 << QUAD_SHIFT) - 1)) << (16 - QUAD_SHIFT);
        if ((quad & 1) != 0) begin
            x = 65536 - x;
        end
        x2   = (x * x) >> 16;
        poly = POLY_C9;
        poly = POLY_C7 - ((x2 * poly) >> 16);
        poly = POLY_C5 - ((x2 * poly) >> 16);
        poly = POLY_C3 - ((x2 * poly) >> 16);
        poly = POLY_C1 - ((x2 * poly) >> 16);
        mag  = (x * poly) >> 16;
        mag  = (mag + 16384) >> 15;
        if (mag > 32767) begin
            mag = 32767;
        end
        half  = period_reg >> 1;
        level = (quad >= 2) ? half * (32768 - mag) : half * (32768 + mag);
        scale = (pct > PCT_FULL) ? PCT_FULL : pct;
        return 16'((level * scale) / FULL_SCALE);
    endfunction

    task automatic write_setting(input logic [2:0] idx, input logic [23:0] data);
        case (idx)
            CFG_TIMER_PERIOD: period_reg  = data[15:0];
            CFG_PCT_ROLL:     pct_reg[0]  = data[6:0];
            CFG_PCT_PITCH:    pct_reg[1]  = data[6:0];
            CFG_PCT_YAW:      pct_reg[2]  = data[6:0];
            CFG_SLEW_ROLL:    slew_reg[0] = data;
            CFG_SLEW_PITCH:   slew_reg[1] = data;
            CFG_SLEW_YAW:     slew_reg[2] = data;
            CFG_OUTPUTS:      outputs_reg = data[3:0];
            default: ;
        endcase
    endtask

    task automatic take_item(input tsc_in_t item);
        longint      target, step, bound;
        int          last_wired;
        logic [31:0] angle;
        case (item.kind)
            KIND_SPEED: if (item.motor < MOTORS) begin
                target = longint'($signed(item.target_speed));
                step   = target - longint'(speed_turns[item.motor]);
                if (slew_reg[item.motor] != 0) begin
                    bound = longint'(slew_reg[item.motor]) * longint'(item.elapsed_ticks);
                    if (step > bound) step = bound;
                    if (step < -bound) step = -bound;
                end
                speed_turns[item.motor] = 32'(longint'(speed_turns[item.motor]) + step);
            end
            KIND_LAG: if (item.motor < MOTORS) begin
                lag_turns[item.motor] = item.lag_phase;
            end
            KIND_TICK: begin
                last_wired = -1;
                for (int mi = 0; mi < MOTORS; mi++) begin
                    if (WINDINGS * (mi + 1) <= outputs_reg) last_wired = mi;
                end
                for (int mi = 0; mi < MOTORS; mi++) begin
                    phase_turns[mi] = (phase_turns[mi] + speed_turns[mi]) & PHASE_KEEP;
                    if (mi <= last_wired) begin
                        for (int w = 0; w < WINDINGS; w++) begin
                            angle = phase_turns[mi] + lag_turns[mi] + winding_offset(w);
                            due.output_index  = 4'(mi * WINDINGS + w);
                            due.compare_value = compare_level(angle, pct_reg[mi]);
                            due.last = (mi == last_wired) && (w == WINDINGS - 1);
                            compare_due.push_back(due);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_beat(input tsc_out_t got);
        if (compare_due.size() == 0) begin
            $error("unexpected result beat: output_index %0d compare_value %0d",
                   got.output_index, got.compare_value);
            mismatches++;
        end else begin
            due = compare_due.pop_front();
            if (got.output_index !== due.output_index) begin
                $error("output_index: expected %0d, got %0d",
                       due.output_index, got.output_index);
                mismatches++;
            end
            if (got.compare_value !== due.compare_value) begin
                $error("compare_value: expected %0d, got %0d",
                       due.compare_value, got.compare_value);
                mismatches++;
            end
            if (got.last !== due.last) begin
                $error("last: expected %0b, got %0b", due.last, got.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  = TIMER_PERIOD_RST;
            outputs_reg = OUTPUTS_RST;
            for (int mi = 0; mi < 3; mi++) begin
                pct_reg[mi]     = '0;
                slew_reg[mi]    = '0;
                phase_turns[mi] = '0;
                speed_turns[mi] = '0;
                lag_turns[mi]   = '0;
            end
            compare_due.delete();
        end else begin
            if (cfg_wr_en) write_setting(cfg_index, cfg_wdata);
            if (s_valid && s_ready) take_item(s_item);
            if (m_valid && m_ready) check_beat(m_item);
        end
        fail_count    <= mismatches;
        pending_beats <= compare_due.size();
    end

endmodule

// ----- tb/three_phase_sine_commutator_tb.sv -----
`timescale 1ns / 1ps

module three_phase_sine_commutator_tb;
    import tsc_pkg::*;

    localparam int REG_COUNT    = 8;
    // longest tick is the one for nine outputs; leave margin on top
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 20;
    // kind and motor codes that the block must drop
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [1:0] MOTOR_ABSENT = 2'd3;
    localparam logic [1:0] MOTOR_ROLL   = 2'd0;
    localparam logic [1:0] MOTOR_PITCH  = 2'd1;
    localparam logic [1:0] MOTOR_YAW    = 2'd2;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    tsc_in_t                  s_item    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    tsc_out_t                 m_item;
    logic                     cfg_wr_en = 1'b0;
    logic [2:0]               cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    int   fail_count;
    int   pending_beats;
    // steady: no idling on either side for the current phase
    logic steady = 1'b0;
    int   stall_left = 0;

    logic [CFG_DATA_BITS-1:0] setting [REG_COUNT];

    always #2 aclk = ~aclk;

    three_phase_sine_commutator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    compare_value_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    // Idle length: mostly short, sometimes medium, rarely long.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 48);
    endfunction

    // Receiver: drop ready for random stretches unless the phase runs steady.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady && $urandom_range(0, 9) < 3) begin
            m_ready    <= 1'b0;
            stall_left <= idle_length() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic tsc_in_t build_item(input logic [1:0] kind, input logic [1:0] motor,
                                           input logic [31:0] target,
                                           input logic [7:0] elapsed,
                                           input logic [31:0] lag);
        tsc_in_t item;
        item.kind          = kind;
        item.motor         = motor;
        item.target_speed  = target;
        item.elapsed_ticks = elapsed;
        item.lag_phase     = lag;
        return item;
    endfunction

    // Mostly ticks, speeds and lags; a few dropped kinds and motors.
    function automatic tsc_in_t random_item();
        tsc_in_t item;
        int      pick;
        item.lag_phase = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45)      item.kind = KIND_TICK;
        else if (pick < 72) item.kind = KIND_SPEED;
        else if (pick < 92) item.kind = KIND_LAG;
        else                item.kind = KIND_UNUSED;
        item.motor = ($urandom_range(0, 9) == 0) ? MOTOR_ABSENT : 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 40)      item.target_speed = $urandom;
        else if (pick < 85) item.target_speed = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        else if (pick < 93) item.target_speed = 32'h7FFF_FFFF;
        else                item.target_speed = 32'h8000_0000;
        pick = $urandom_range(0, 99);
        if (pick < 20)      item.elapsed_ticks = 8'd0;
        else if (pick < 35) item.elapsed_ticks = 8'd255;
        else                item.elapsed_ticks = 8'($urandom_range(1, 254));
        return item;
    endfunction

    function automatic logic [23:0] random_pct();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 24'($urandom_range(101, 127));
        if (pick < 18) return 24'(PCT_FULL);
        if (pick < 24) return 24'd0;
        return 24'($urandom_range(0, 100));
    endfunction

    function automatic logic [23:0] random_slew();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 24'd0;
        if (pick < 70) return 24'($urandom_range(1, 4096));
        if (pick < 80) return 24'hFF_FFFF;
        return 24'($urandom_range(1, 24'hFF_FFFF));
    endfunction

    task automatic random_settings();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)      setting[CFG_TIMER_PERIOD] = 24'd65535;
        else if (pick < 25) setting[CFG_TIMER_PERIOD] = 24'd2;
        else                setting[CFG_TIMER_PERIOD] = 24'($urandom_range(2, 65535));
        setting[CFG_PCT_ROLL]   = random_pct();
        setting[CFG_PCT_PITCH]  = random_pct();
        setting[CFG_PCT_YAW]    = random_pct();
        setting[CFG_SLEW_ROLL]  = random_slew();
        setting[CFG_SLEW_PITCH] = random_slew();
        setting[CFG_SLEW_YAW]   = random_slew();
        setting[CFG_OUTPUTS] = ($urandom_range(0, 9) < 6) ? 24'(OUTPUTS_RST)
                                                          : 24'($urandom_range(0, 9));
    endtask

    // Write every register, one per cycle; hold the enable high across the burst.
    task automatic program_registers();
        for (int idx = 0; idx < REG_COUNT; idx++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(idx);
            cfg_wdata <= setting[idx];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Present one beat after an optional gap and hold it until accepted.
    task automatic send_item(input tsc_in_t item);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 1) == 1) gap = idle_length();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, wait for every expected beat, then let the block go quiet.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_beats != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic wiring_tick(input logic [23:0] wired);
        setting[CFG_OUTPUTS] = wired;
        program_registers();
        send_item(build_item(KIND_TICK, MOTOR_ROLL, $urandom, 8'($urandom), $urandom));
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes: full period, full and over-range percent, no slew limit.
        setting[CFG_TIMER_PERIOD] = 24'd65535;
        setting[CFG_PCT_ROLL]     = 24'(PCT_FULL);
        setting[CFG_PCT_PITCH]    = 24'd127;
        setting[CFG_PCT_YAW]      = 24'd50;
        setting[CFG_SLEW_ROLL]    = 24'd0;
        setting[CFG_SLEW_PITCH]   = 24'd0;
        setting[CFG_SLEW_YAW]     = 24'd0;
        setting[CFG_OUTPUTS]      = 24'(OUTPUTS_RST);
        program_registers();
        send_item(build_item(KIND_TICK, MOTOR_ROLL, 32'd0, 8'd0, 32'd0));
        send_item(build_item(KIND_LAG, MOTOR_ROLL, 32'd0, 8'd0, 32'hFFFF_FFFF));
        send_item(build_item(KIND_LAG, MOTOR_PITCH, 32'd0, 8'd0, 32'h4000_0000));
        send_item(build_item(KIND_LAG, MOTOR_YAW, 32'd0, 8'd0, 32'h8000_0000));
        // dropped beats: absent motor, unused kind
        send_item(build_item(KIND_LAG, MOTOR_ABSENT, 32'd0, 8'd0, 32'h1234_5678));
        send_item(build_item(KIND_TICK, MOTOR_ROLL, 32'd0, 8'd0, 32'd0));
        send_item(build_item(KIND_SPEED, MOTOR_ROLL, 32'h7FFF_FFFF, 8'd0, 32'd0));
        send_item(build_item(KIND_SPEED, MOTOR_PITCH, 32'h8000_0000, 8'd0, 32'd0));
        send_item(build_item(KIND_SPEED, MOTOR_YAW, 32'h0040_0000, 8'd255, 32'd0));
        send_item(build_item(KIND_SPEED, MOTOR_ABSENT, 32'h0100_0000, 8'd9, 32'd0));
        send_item(build_item(KIND_UNUSED, MOTOR_ROLL, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF));
        send_item(build_item(KIND_TICK, MOTOR_ROLL, 32'd0, 8'd0, 32'd0));
        send_item(build_item(KIND_TICK, MOTOR_ROLL, 32'd0, 8'd0, 32'd0));
        drain();

        // Slew limits at both ends, zero elapsed ticks, smallest period.
        setting[CFG_TIMER_PERIOD] = 24'd2;
        setting[CFG_PCT_ROLL]     = 24'd1;
        setting[CFG_PCT_PITCH]    = 24'd0;
        setting[CFG_PCT_YAW]      = 24'(PCT_FULL);
        setting[CFG_SLEW_ROLL]    = 24'hFF_FFFF;
        setting[CFG_SLEW_PITCH]   = 24'd1;
        setting[CFG_SLEW_YAW]     = 24'd1000;
        setting[CFG_OUTPUTS]      = 24'd3;
        program_registers();
        send_item(build_item(KIND_SPEED, MOTOR_ROLL, 32'h8000_0000, 8'd255, 32'd0));
        send_item(build_item(KIND_SPEED, MOTOR_PITCH, 32'd0, 8'd0, 32'd0));
        send_item(build_item(KIND_SPEED, MOTOR_PITCH, 32'h7FFF_FFFF, 8'd200, 32'd0));
        send_item(build_item(KIND_SPEED, MOTOR_YAW, 32'd0, 8'd255, 32'd0));
        send_item(build_item(KIND_TICK, MOTOR_ROLL, 32'd0, 8'd0, 32'd0));
        send_item(build_item(KIND_TICK, MOTOR_ROLL, 32'd0, 8'd0, 32'd0));
        drain();

        // Wiring: nothing wired, two motors, one short of the third.
        setting[CFG_TIMER_PERIOD] = 24'(TIMER_PERIOD_RST);
        setting[CFG_PCT_ROLL]     = 24'(PCT_FULL);
        setting[CFG_PCT_PITCH]    = 24'(PCT_FULL);
        setting[CFG_PCT_YAW]      = 24'(PCT_FULL);
        wiring_tick(24'd0);
        wiring_tick(24'd6);
        wiring_tick(24'd8);

        // Random phases, each under its own register set; one runs without idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_settings();
            steady <= (phase == 2);
            program_registers();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
